// ===== rtl/assert_macros.svh =====
// Assertion helpers. Clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define AST_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hts_pkg.sv =====
`timescale 1ns / 1ps

package hts_pkg;

  localparam int unsigned LINE_MAX_DEF = 256;
  localparam int unsigned LEN_W        = 9;
  localparam logic [8:0]  LINE_LEN_RST = 9'd16;
  localparam int unsigned NBANDS       = 10;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // 25 * 256 * |g| >= 256 once 625 * (dx^2 + dy^2) >= 2^24.
  localparam logic [15:0] SLOPE_CLIP   = 16'd164;
  localparam logic [15:0] SUM_CLIP     = 16'd26844;
  localparam logic [9:0]  SLOPE_GAIN   = 10'd625;
  localparam logic [8:0]  SHADE_ONE    = 9'd256;
  localparam int unsigned ROOT_STEPS   = 8;

  typedef logic signed [15:0] height_t;

  typedef struct packed {
    logic [7:0] dx_mag;
    logic [7:0] dy_mag;
    logic       steep;
    logic       below_sea;
    logic [3:0] band;
  } work_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_SCALE,
    B_ROOT,
    B_SHADE
  } back_state_e;

  // Q3.12 lower bound of each band; band 0 lies below everything.
  function automatic height_t band_floor(input logic [3:0] i);
    height_t t;
    case (i)
      4'd1:    t = -16'sd1639;
      4'd2:    t = -16'sd820;
      4'd3:    t = -16'sd410;
      4'd4:    t = 16'sd0;
      4'd5:    t = 16'sd409;
      4'd6:    t = 16'sd819;
      4'd7:    t = 16'sd2048;
      4'd8:    t = 16'sd2867;
      4'd9:    t = 16'sd3276;
      default: t = 16'sd0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] band_index(input height_t h);
    logic [3:0] idx;
    idx = '0;
    for (int i = 1; i < NBANDS; i++) begin
      if (band_floor(4'(i)) < h) idx = 4'(i);
    end
    return idx;
  endfunction

  // {red, green, blue}
  function automatic logic [23:0] band_rgb(input logic [3:0] i);
    logic [23:0] c;
    case (i)
      4'd0:    c = {8'd0,   8'd10,  8'd160};
      4'd1:    c = {8'd0,   8'd15,  8'd190};
      4'd2:    c = {8'd0,   8'd0,   8'd255};
      4'd3:    c = {8'd0,   8'd128, 8'd192};
      4'd4:    c = {8'd239, 8'd228, 8'd176};
      4'd5:    c = {8'd128, 8'd64,  8'd0};
      4'd6:    c = {8'd0,   8'd128, 8'd0};
      4'd7:    c = {8'd192, 8'd192, 8'd192};
      4'd8:    c = {8'd220, 8'd240, 8'd240};
      4'd9:    c = {8'd240, 8'd255, 8'd255};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/height_tint_slope_shade.sv =====
`timescale 1ns / 1ps

// Hypsometric tint with slope shading for a raster stream of Q3.12 heights.
// Input channel: in_valid_i/in_ready_o with height_i and frame_start_i; one
// transfer per sample. frame_start_i restarts the column and first-row state.
// Output channel: out_valid_o/out_ready_i with red_o, green_o, blue_o and
// palette_index_o; one pixel per input sample, in order.
// line_length_we_i writes line_length_i (samples per row); the user must write
// it only while idle, the block itself does not enforce this. The back end
// takes one sample at a time through operand load, squaring, scaling, an
// 8-step square root (one digit per cycle) and shading, then takes the next.
// The front end (line store read, differences, band select) runs ahead into
// a two-entry queue, so it keeps taking samples while the back end works.
// Reset: row length returns to 16, column 0, next row is a first row; the
// line store is not cleared, no pass is needed and input is taken at once.
// Receiver stall: the result waits in the output register; the back end
// holds its finished pixel, then the queue fills, then in_ready_o drops.
module height_tint_slope_shade #(
  parameter int unsigned LINE_MAX = hts_pkg::LINE_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               line_length_we_i,
  input  logic [8:0]         line_length_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] height_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [3:0]         palette_index_o
);

  logic           push, push_ready, pop, pop_valid;
  hts_pkg::work_t push_data, pop_data;

  hts_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .line_length_we_i (line_length_we_i),
    .line_length_i    (line_length_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .height_i         (height_i),
    .frame_start_i    (frame_start_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .push_ready_i     (push_ready)
  );

  hts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  hts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .palette_index_o (palette_index_o)
  );

endmodule

// ===== rtl/hts_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_front #(
  parameter int unsigned LINE_MAX = hts_pkg::LINE_MAX_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   line_length_we_i,
  input  logic [8:0]             line_length_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [15:0]     height_i,
  input  logic                   frame_start_i,
  output logic                   push_o,
  output hts_pkg::work_t         push_data_o,
  input  logic                   push_ready_i
);

  localparam int unsigned COL_W  = $clog2(LINE_MAX);
  localparam int unsigned LMAX_W = $clog2(LINE_MAX + 1);
  localparam int unsigned CMP_W  = (LMAX_W > hts_pkg::LEN_W) ? LMAX_W : hts_pkg::LEN_W;

  logic [8:0]       len_q;
  logic [COL_W-1:0] col_q, col_d;
  logic             first_row_q, first_row_d;
  hts_pkg::height_t left_q;

  logic [15:0]      row_mem [LINE_MAX];
  logic [15:0]      above_q;

  logic             p_valid_q, p_valid_d;
  hts_pkg::height_t p_h_q;
  logic [16:0]      p_dx_q;
  logic             p_first_row_q;

  logic             accept;
  logic [CMP_W-1:0] len_ext, len_eff, col_next_ext;
  logic [COL_W-1:0] col_cur;
  logic             first_cur, row_end;
  logic [16:0]      dx_now, dy, dx_abs, dy_abs;
  logic             steep;

  assign in_ready_o = !p_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Row bookkeeping at the input transfer
  always_comb begin
    len_ext = CMP_W'(len_q);
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(LINE_MAX)) begin
      len_eff = CMP_W'(LINE_MAX);
    end else begin
      len_eff = len_ext;
    end
    col_cur      = frame_start_i ? '0 : col_q;
    first_cur    = frame_start_i || first_row_q;
    col_next_ext = CMP_W'(col_cur) + CMP_W'(1);
    row_end      = col_next_ext >= len_eff;
    col_d        = col_q;
    first_row_d  = first_row_q;
    if (accept) begin
      col_d       = row_end ? '0 : COL_W'(col_next_ext);
      first_row_d = row_end ? 1'b0 : first_cur;
    end
    dx_now = (col_cur == '0) ? 17'd0
           : ({height_i[15], height_i} - {left_q[15], left_q});
    p_valid_d = accept ? 1'b1 : (push_ready_i ? 1'b0 : p_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= hts_pkg::LINE_LEN_RST;
      col_q       <= '0;
      first_row_q <= 1'b1;
      left_q      <= '0;
      p_valid_q   <= 1'b0;
    end else begin
      if (line_length_we_i) len_q <= line_length_i;
      col_q       <= col_d;
      first_row_q <= first_row_d;
      if (accept) left_q <= height_i;
      p_valid_q   <= p_valid_d;
    end
  end

  // Line store: old value out, new sample in, same address
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q          <= row_mem[col_cur];
      row_mem[col_cur] <= height_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_h_q         <= height_i;
      p_dx_q        <= dx_now;
      p_first_row_q <= first_cur;
    end
  end

  // Classify: differences, clip to the range where the shade is nonzero, band select
  always_comb begin
    dy     = p_first_row_q ? 17'd0 : ({p_h_q[15], p_h_q} - {above_q[15], above_q});
    dx_abs = p_dx_q[16] ? (17'd0 - p_dx_q) : p_dx_q;
    dy_abs = dy[16] ? (17'd0 - dy) : dy;
    steep  = (dx_abs[15:0] >= hts_pkg::SLOPE_CLIP) || (dy_abs[15:0] >= hts_pkg::SLOPE_CLIP);
    push_data_o.dx_mag    = steep ? 8'd0 : dx_abs[7:0];
    push_data_o.dy_mag    = steep ? 8'd0 : dy_abs[7:0];
    push_data_o.steep     = steep;
    push_data_o.below_sea = p_h_q[15];
    push_data_o.band      = hts_pkg::band_index(p_h_q);
  end

  assign push_o = p_valid_q;

  `AST_ALWAYS(col_in_range, col_q < COL_W'(LINE_MAX - 1) || col_q == COL_W'(LINE_MAX - 1),
    "column counter ran past the line store")

endmodule

// ===== rtl/hts_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hts_pkg::work_t push_data_i,
  output logic           push_ready_o,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output hts_pkg::work_t pop_data_o
);

  localparam int unsigned DEPTH = hts_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hts_pkg::work_t   ent_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= push_data_i;
  end

  `AST_ALWAYS(q_count_bound, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
  `AST_IMPLIES(q_empty_ptrs, count_q == '0, wr_ptr_q == rd_ptr_q,
    "queue empty but pointers differ")

endmodule

// ===== rtl/hts_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  hts_pkg::work_t pop_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o,
  output logic [3:0]     palette_index_o
);

  hts_pkg::back_state_e state_q, state_d;

  hts_pkg::work_t w_q;
  logic [15:0]    sum_q;
  logic [15:0]    x_q;
  logic [15:0]    r_q;
  logic           steep_q;
  logic [2:0]     cnt_q;

  logic           out_valid_q, out_valid_d;
  logic [7:0]     red_q, green_q, blue_q;
  logic [3:0]     band_q;

  logic           slot_free, load_out;
  logic [25:0]    scaled;
  logic [15:0]    root_bit, r_next, x_next;
  logic [16:0]    trial;
  logic [8:0]     shade;
  logic [23:0]    rgb;
  logic [16:0]    red_prod, green_prod, blue_prod;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hts_pkg::B_IDLE:   if (pop_valid_i) state_d = hts_pkg::B_SQUARE;
      hts_pkg::B_SQUARE: state_d = hts_pkg::B_SCALE;
      hts_pkg::B_SCALE:  state_d = hts_pkg::B_ROOT;
      hts_pkg::B_ROOT:   if (cnt_q == '0) state_d = hts_pkg::B_SHADE;
      hts_pkg::B_SHADE:  if (slot_free) state_d = hts_pkg::B_IDLE;
      default:           state_d = hts_pkg::B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      hts_pkg::B_IDLE:  pop_o    = pop_valid_i;
      hts_pkg::B_SHADE: load_out = slot_free;
      default: ;
    endcase
  end

  // Datapath: scaling, one root digit per cycle in restoring form, shading
  always_comb begin
    scaled   = 26'(sum_q) * 26'(hts_pkg::SLOPE_GAIN);
    root_bit = 16'd1 << {cnt_q, 1'b0};
    trial    = 17'(r_q) + 17'(root_bit);
    if (17'(x_q) >= trial) begin
      x_next = x_q - trial[15:0];
      r_next = (r_q >> 1) + root_bit;
    end else begin
      x_next = x_q;
      r_next = r_q >> 1;
    end
    if (w_q.below_sea) begin
      shade = hts_pkg::SHADE_ONE;
    end else if (steep_q) begin
      shade = 9'd0;
    end else begin
      shade = hts_pkg::SHADE_ONE - {1'b0, r_q[7:0]};
    end
    rgb         = hts_pkg::band_rgb(w_q.band);
    red_prod    = 17'(rgb[23:16]) * 17'(shade);
    green_prod  = 17'(rgb[15:8]) * 17'(shade);
    blue_prod   = 17'(rgb[7:0]) * 17'(shade);
    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hts_pkg::B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == hts_pkg::B_SCALE) begin
        cnt_q <= 3'(hts_pkg::ROOT_STEPS - 1);
      end else if (state_q == hts_pkg::B_ROOT) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hts_pkg::B_IDLE: begin
        if (pop_valid_i) w_q <= pop_data_i;
      end
      hts_pkg::B_SQUARE: begin
        sum_q <= ({8'd0, w_q.dx_mag} * {8'd0, w_q.dx_mag})
               + ({8'd0, w_q.dy_mag} * {8'd0, w_q.dy_mag});
      end
      hts_pkg::B_SCALE: begin
        x_q     <= scaled[23:8];
        steep_q <= w_q.steep || (sum_q >= hts_pkg::SUM_CLIP);
        r_q     <= '0;
      end
      hts_pkg::B_ROOT: begin
        x_q <= x_next;
        r_q <= r_next;
      end
      default: ;
    endcase
    if (load_out) begin
      red_q   <= red_prod[15:8];
      green_q <= green_prod[15:8];
      blue_q  <= blue_prod[15:8];
      band_q  <= w_q.band;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;
  assign palette_index_o = band_q;

  `AST_IMPLIES(root_fits, state_q == hts_pkg::B_SHADE, r_q[15:8] == 8'd0,
    "slope root exceeds eight bits")

endmodule
